// ===== hdl/sfh_pkg.sv =====
// Package for the sparse feature histogram.
// Field widths, table depth default and controller state type; no dependencies.
package sfh_pkg;

  localparam int FeaturesDefault = 4096;
  localparam int CfgWidth        = 13;
  localparam int IndexWidth      = 16;
  localparam int CountWidth      = 16;
  localparam int TotalWidth      = 32;
  localparam int RangeWidth      = 16;
  localparam logic [CfgWidth-1:0] CfgReset = 13'd4096;

  localparam logic OP_ACCUMULATE = 1'b0;
  localparam logic OP_READ_CLEAR = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR  = 3'b001,
    ST_IDLE   = 3'b010,
    ST_UPDATE = 3'b100
  } sfh_state_t;

endpackage

// ===== hdl/sfh_if.sv =====
// Valid/ready channel interfaces for the sparse feature histogram.
// Depends on sfh_pkg for field widths.
interface sfh_item_if import sfh_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic                  op;
  logic [IndexWidth-1:0] feature_index;
  logic [CountWidth-1:0] entry_count;
  modport source (output valid, op, feature_index, entry_count, input ready);
  modport sink   (input valid, op, feature_index, entry_count, output ready);
endinterface

interface sfh_result_if import sfh_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [TotalWidth-1:0] total_count;
  logic [RangeWidth-1:0] doc_range;
  logic                  range_error;
  modport source (output valid, total_count, doc_range, range_error, input ready);
  modport sink   (input valid, total_count, doc_range, range_error, output ready);
endinterface

interface sfh_cfg_if import sfh_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CfgWidth-1:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ===== hdl/sfh_store.sv =====
// Feature tables: total and range memories, one write and one registered read port.
// Depends on sfh_pkg for field widths.
module sfh_store import sfh_pkg::*; #(
  parameter int FEATURES = FeaturesDefault,
  parameter int AW = $clog2(FEATURES)
) (
  input  logic                  clk,
  input  logic                  we,
  input  logic [AW-1:0]         waddr,
  input  logic [TotalWidth-1:0] wtotal,
  input  logic [RangeWidth-1:0] wrange,
  input  logic                  re,
  input  logic [AW-1:0]         raddr,
  output logic [TotalWidth-1:0] rtotal,
  output logic [RangeWidth-1:0] rrange
);

  logic [TotalWidth-1:0] total_mem [FEATURES];
  logic [RangeWidth-1:0] range_mem [FEATURES];

  always_ff @(posedge clk) begin
    if (we) begin
      total_mem[waddr] <= wtotal;
      range_mem[waddr] <= wrange;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rtotal <= total_mem[raddr];
      rrange <= range_mem[raddr];
    end
  end

endmodule

// ===== hdl/sparse_feature_histogram.sv =====
// Top level of the sparse feature histogram: controller, config register, result register.
// Depends on sfh_pkg, sfh_if and sfh_store.
//
//   channel  dir  fields
//   cfg      in   data (features_in_use)
//   item     in   op, feature_index, entry_count
//   result   out  total_count, doc_range, range_error
//
// Each item takes one memory read, then modify and write back.
// The next item is taken the cycle after write back, so no entry hazard arises.
// After reset a clearing pass zeroes both tables; items wait.
// A stalled result holds the update stage; cfg is always ready.
module sparse_feature_histogram import sfh_pkg::*; #(
  parameter int FEATURES = FeaturesDefault
) (
  input  logic         clk,
  input  logic         rst,
  sfh_cfg_if.sink      cfg,
  sfh_item_if.sink     item,
  sfh_result_if.source result
);

  localparam int AW = $clog2(FEATURES);

  sfh_state_t            state;
  logic [CfgWidth-1:0]   features_in_use;
  logic [AW-1:0]         clr_cnt;
  logic                  op_r;
  logic [CountWidth-1:0] cnt_r;
  logic [AW-1:0]         addr_r;
  logic                  err_r;
  logic                  res_valid;
  logic [TotalWidth-1:0] res_total;
  logic [RangeWidth-1:0] res_range;
  logic                  res_err;

  logic                  accept;
  logic                  advance;
  logic                  item_err;
  logic                  we;
  logic [AW-1:0]         waddr;
  logic [TotalWidth-1:0] wtotal;
  logic [RangeWidth-1:0] wrange;
  logic [TotalWidth-1:0] rtotal;
  logic [RangeWidth-1:0] rrange;
  logic [TotalWidth-1:0] sum_total;
  logic [RangeWidth-1:0] inc_range;

  assign cfg.ready    = 1'b1;
  assign item.ready   = (state == ST_IDLE);
  assign accept       = item.valid && item.ready;
  assign advance      = !res_valid || result.ready;
  assign item_err     = (32'(item.feature_index) >= 32'(features_in_use)) ||
                        (32'(item.feature_index) >= 32'(FEATURES));
  assign sum_total    = rtotal + TotalWidth'(cnt_r);
  assign inc_range    = (rrange == {RangeWidth{1'b1}}) ? rrange : rrange + 1'b1;

  assign result.valid       = res_valid;
  assign result.total_count = res_total;
  assign result.doc_range   = res_range;
  assign result.range_error = res_err;

  always_comb begin
    we     = 1'b0;
    waddr  = addr_r;
    wtotal = '0;
    wrange = '0;
    case (state)
      ST_CLEAR: begin
        we    = 1'b1;
        waddr = clr_cnt;
      end
      ST_UPDATE: begin
        we = advance && !err_r;
        if (op_r == OP_ACCUMULATE) begin
          wtotal = sum_total;
          wrange = inc_range;
        end
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  sfh_store #(.FEATURES(FEATURES), .AW(AW)) u_store (
    .clk    (clk),
    .we     (we),
    .waddr  (waddr),
    .wtotal (wtotal),
    .wrange (wrange),
    .re     (accept),
    .raddr  (AW'(item.feature_index)),
    .rtotal (rtotal),
    .rrange (rrange)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      features_in_use <= CfgReset;
    end else if (cfg.valid && cfg.ready) begin
      features_in_use <= cfg.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_cnt   <= '0;
      res_valid <= 1'b0;
    end else begin
      res_valid <= (state == ST_UPDATE && advance) || (res_valid && !result.ready);
      case (state)
        ST_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == AW'(FEATURES - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            state <= ST_UPDATE;
          end
        end
        ST_UPDATE: begin
          if (advance) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r   <= item.op;
      cnt_r  <= item.entry_count;
      addr_r <= AW'(item.feature_index);
      err_r  <= item_err;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_UPDATE && advance) begin
      res_err <= err_r;
      if (err_r) begin
        res_total <= '0;
        res_range <= '0;
      end else if (op_r == OP_ACCUMULATE) begin
        res_total <= sum_total;
        res_range <= inc_range;
      end else begin
        res_total <= rtotal;
        res_range <= rrange;
      end
    end
  end

endmodule

// ===== sim/sfh_checker.sv =====
// Checker for the sparse feature histogram: watches the cfg, item and result channels.
// Predicts each result from its own copy of both tables and compares in order.
// Depends on sfh_pkg and the channel interfaces in sfh_if.
module sfh_checker import sfh_pkg::*; #(
  parameter int FEATURES = FeaturesDefault
) (
  input  logic   clk,
  input  logic   rst,
  sfh_cfg_if     cfg,
  sfh_item_if    item,
  sfh_result_if  result,
  output int     fail_count,
  output int     pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int AW = $clog2(FEATURES);

  typedef struct packed {
    logic [TotalWidth-1:0] total_count;
    logic [RangeWidth-1:0] doc_range;
    logic                  range_error;
  } histo_result_t;

  logic [TotalWidth-1:0] total_tbl [FEATURES];
  logic [RangeWidth-1:0] range_tbl [FEATURES];
  logic [CfgWidth-1:0]   features_in_use;
  histo_result_t         expected_q [$];

  function automatic histo_result_t apply_entry(input logic op,
                                                input logic [IndexWidth-1:0] idx,
                                                input logic [CountWidth-1:0] cnt);
    histo_result_t r;
    int unsigned   limit;
    logic [AW-1:0] a;
    r = '0;
    limit = 32'(features_in_use);
    if (limit > FEATURES) limit = FEATURES;
    if (idx >= limit) begin
      r.range_error = 1'b1;
      return r;
    end
    a = AW'(idx);
    if (op == OP_ACCUMULATE) begin
      total_tbl[a] = total_tbl[a] + TotalWidth'(cnt);
      if (range_tbl[a] != '1) range_tbl[a] = range_tbl[a] + 1'b1;
    end
    r.total_count = total_tbl[a];
    r.doc_range   = range_tbl[a];
    if (op == OP_READ_CLEAR) begin
      total_tbl[a] = '0;
      range_tbl[a] = '0;
    end
    return r;
  endfunction

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    histo_result_t want;
    histo_result_t next_exp;
    if (rst) begin
      features_in_use = CfgReset;
      expected_q.delete();
      fail_count = 0;
      total_tbl = '{default: '0};
      range_tbl = '{default: '0};
    end else begin
      if (cfg.valid && cfg.ready) features_in_use = cfg.data;
      if (result.valid && result.ready) begin
        if (expected_q.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result, expected none, actual total %0h range %0h err %0b",
                   $time, result.total_count, result.doc_range, result.range_error);
        end else begin
          want = expected_q.pop_front();
          compare_field("total_count", want.total_count, result.total_count);
          compare_field("doc_range", 32'(want.doc_range), 32'(result.doc_range));
          compare_field("range_error", 32'(want.range_error), 32'(result.range_error));
        end
      end
      if (item.valid && item.ready) begin
        next_exp = apply_entry(item.op, item.feature_index, item.entry_count);
        expected_q = {expected_q, next_exp};
      end
    end
    pending = expected_q.size();
  end

endmodule

// ===== sim/tb.sv =====
// Testbench top for the sparse feature histogram: clock, reset, stimulus and verdict.
// Directed entries, random phases over several feature limits, then a run on one entry.
// Depends on sfh_pkg, sfh_if, sparse_feature_histogram and sfh_checker.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sfh_pkg::*;

  localparam int FEATURES = FeaturesDefault;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  int          fail_count;
  int          pending;
  int          idle_odds = 4;
  int unsigned cur_limit = 4096;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  sfh_cfg_if    cfg_ch ();
  sfh_item_if   item_ch ();
  sfh_result_if result_ch ();

  sparse_feature_histogram #(.FEATURES(FEATURES)) dut (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg_ch),
    .item   (item_ch),
    .result (result_ch)
  );

  sfh_checker #(.FEATURES(FEATURES)) histo_check (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg_ch),
    .item       (item_ch),
    .result     (result_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  task automatic send_entry(input logic op, input logic [IndexWidth-1:0] idx,
                            input logic [CountWidth-1:0] cnt);
    item_ch.valid         <= 1'b1;
    item_ch.op            <= op;
    item_ch.feature_index <= idx;
    item_ch.entry_count   <= cnt;
    do @(posedge clk); while (!item_ch.ready);
    if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
      item_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  endtask

  task automatic drain();
    item_ch.valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_limit(input logic [CfgWidth-1:0] value);
    drain();
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    cur_limit = 32'(value);
  endtask

  task automatic random_phase(input int n);
    int unsigned           span;
    int                    pick;
    logic                  op;
    logic [IndexWidth-1:0] idx;
    logic [CountWidth-1:0] cnt;
    span = (cur_limit > FEATURES) ? FEATURES : cur_limit;
    repeat (n) begin
      pick = $urandom_range(0, 99);
      op = ($urandom_range(0, 3) == 0) ? OP_READ_CLEAR : OP_ACCUMULATE;
      if (span == 0 || pick < 10) idx = IndexWidth'($urandom());
      else if (pick < 20) idx = IndexWidth'(span - 1 + $urandom_range(0, 1));
      else if (pick < 35) idx = IndexWidth'($urandom_range(0, span - 1));
      else idx = IndexWidth'($urandom_range(0, (span < 8) ? span - 1 : 7));
      pick = $urandom_range(0, 9);
      if (pick == 0) cnt = '0;
      else if (pick == 1) cnt = '1;
      else cnt = CountWidth'($urandom());
      send_entry(op, idx, cnt);
    end
  endtask

  initial begin
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (idle_odds != 0 && $urandom_range(1, 2 * idle_odds) == 1) begin
        result_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
      result_ch.ready <= 1'b1;
    end
  end

  initial begin
    cfg_ch.valid          <= 1'b0;
    cfg_ch.data           <= '0;
    item_ch.valid         <= 1'b0;
    item_ch.op            <= OP_ACCUMULATE;
    item_ch.feature_index <= '0;
    item_ch.entry_count   <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    send_entry(OP_ACCUMULATE, 16'd0, 16'd0);
    send_entry(OP_ACCUMULATE, 16'd0, 16'hFFFF);
    send_entry(OP_READ_CLEAR, 16'd0, 16'hFFFF);
    send_entry(OP_READ_CLEAR, 16'd0, 16'd0);
    send_entry(OP_READ_CLEAR, 16'd100, 16'd0);
    send_entry(OP_ACCUMULATE, 16'd4095, 16'hFFFF);
    send_entry(OP_ACCUMULATE, 16'd4095, 16'd1);
    send_entry(OP_READ_CLEAR, 16'd4095, 16'd0);
    send_entry(OP_ACCUMULATE, 16'd4096, 16'd7);
    send_entry(OP_READ_CLEAR, 16'd4096, 16'd0);
    send_entry(OP_ACCUMULATE, 16'hFFFF, 16'hFFFF);
    send_entry(OP_READ_CLEAR, 16'hFFFF, 16'hFFFF);
    send_entry(OP_ACCUMULATE, 16'h5555, 16'hAAAA);
    send_entry(OP_ACCUMULATE, 16'h0AAA, 16'h5555);
    send_entry(OP_READ_CLEAR, 16'h0AAA, 16'hAAAA);
    send_entry(OP_ACCUMULATE, 16'd1, 16'h8000);
    send_entry(OP_ACCUMULATE, 16'd1, 16'h8000);
    send_entry(OP_READ_CLEAR, 16'd1, 16'd0);

    write_limit(13'd1);
    send_entry(OP_ACCUMULATE, 16'd0, 16'd3);
    send_entry(OP_ACCUMULATE, 16'd1, 16'd3);
    send_entry(OP_READ_CLEAR, 16'd0, 16'd0);

    write_limit(13'd0);
    send_entry(OP_ACCUMULATE, 16'd0, 16'd5);
    send_entry(OP_READ_CLEAR, 16'd0, 16'd0);

    write_limit(13'h1FFF);
    send_entry(OP_ACCUMULATE, 16'd4095, 16'd9);
    send_entry(OP_ACCUMULATE, 16'd4096, 16'd9);
    send_entry(OP_READ_CLEAR, 16'd4095, 16'd0);

    write_limit(13'd16);
    random_phase(115);
    idle_odds = 0;
    write_limit(13'd4097);
    random_phase(115);
    idle_odds = 3;
    write_limit(CfgWidth'($urandom_range(1, 4096)));
    random_phase(115);
    idle_odds = 6;
    write_limit(CfgWidth'($urandom_range(0, 8191)));
    random_phase(115);
    idle_odds = 2;
    write_limit(13'h1FFF);
    random_phase(115);
    idle_odds = 0;
    write_limit(13'd4096);
    random_phase(115);

    repeat (20) send_entry(OP_ACCUMULATE, 16'd7, 16'hFFFF);
    send_entry(OP_ACCUMULATE, 16'd7, 16'd5);
    send_entry(OP_READ_CLEAR, 16'd7, 16'd0);

    drain();
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/sfh_pkg.sv
hdl/sfh_if.sv
hdl/sfh_store.sv
hdl/sparse_feature_histogram.sv
sim/sfh_checker.sv
sim/tb.sv
